// ===== rtl/npp_pkg.sv =====
package npp_pkg;

  localparam int MaxRefPoints = 1024;
  localparam int CoordBits    = 16;
  localparam int IdxBits      = $clog2(MaxRefPoints);
  localparam int CntBits      = IdxBits + 1;
  localparam int SqBits       = 2 * (CoordBits + 1) + 2;
  localparam int DistBits     = 17;
  localparam int SumBits      = 40;
  localparam int QcBits       = 21;
  localparam int PointBits    = 3 * CoordBits;
  localparam int NumCells     = 3;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_t;

  // token passed along the distance chain
  typedef struct packed {
    logic               valid;
    logic [IdxBits-1:0] idx;
    logic [SqBits-1:0]  acc;
  } dtok_t;

endpackage

// ===== rtl/npp_ram.sv =====
module npp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/npp_cell.sv =====
module npp_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [npp_pkg::CoordBits-1:0] q,
  input  logic signed [npp_pkg::CoordBits-1:0] r,
  input  npp_pkg::dtok_t                 tin,
  output npp_pkg::dtok_t                 tout
);
  import npp_pkg::*;

  logic signed [CoordBits:0] diff;
  logic        [CoordBits:0] mag;
  logic        [2*CoordBits+1:0] prod;
  logic        [SqBits-1:0]  sq;

  // add one axis' squared difference to the passing token
  always_comb begin
    diff = {q[CoordBits-1], q} - {r[CoordBits-1], r};
    mag  = diff[CoordBits] ? (CoordBits+1)'(-diff) : diff;
    prod = mag * mag;
    sq   = SqBits'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
    tout.idx <= tin.idx;
    tout.acc <= tin.acc + sq;
  end
endmodule

// ===== rtl/nearest_point_pairing.sv =====
// channel | direction | handshake          | payload
// query   | in        | start & !busy      | kind, coord_x/y/z, last_query
// result  | out       | done (one cycle)   | match_*, distance, average_*, no_reference
// Append and clear leave busy low; a query on an empty set answers in the next cycle.
// A query holds busy while the three-cell distance chain scans one point per cycle from
// the RAM and drains, then through the square root, and through the division on a last
// query. The result appears in the same cycle as busy drops.
// Reset empties the reference set and clears the sum and count.
// The receiver cannot stall: done is high for exactly one cycle per result.
module nearest_point_pairing (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           kind,
  input  logic signed [npp_pkg::CoordBits-1:0] coord_x,
  input  logic signed [npp_pkg::CoordBits-1:0] coord_y,
  input  logic signed [npp_pkg::CoordBits-1:0] coord_z,
  input  logic                                 last_query,
  output logic                                 done,
  output logic [9:0]                           match_index,
  output logic signed [npp_pkg::CoordBits-1:0] match_x,
  output logic signed [npp_pkg::CoordBits-1:0] match_y,
  output logic signed [npp_pkg::CoordBits-1:0] match_z,
  output logic [16:0]                          distance,
  output logic                                 average_valid,
  output logic [16:0]                          average_distance,
  output logic                                 no_reference
);
  import npp_pkg::*;

  localparam int SqrtSteps = SqBits / 2;

  state_t state, state_next;
  logic [CntBits-1:0] ref_count;
  logic [SumBits-1:0] dist_sum;
  logic [QcBits-1:0]  query_cnt;
  logic signed [CoordBits-1:0] qx, qy, qz;
  logic               qlast;
  logic [CntBits-1:0] scan_cnt;
  logic               scan_rd;
  logic               rd_valid;
  logic [IdxBits-1:0] rd_idx;
  logic [SqBits-1:0]  best_d;
  logic [IdxBits-1:0] best_idx;
  logic [5:0]         step;
  logic [SqBits-1:0]  sq_rem;
  logic [SqBits-1:0]  sq_val;
  logic [DistBits-1:0] root;
  logic [SumBits-1:0] div_rem;
  logic [SumBits-1:0] div_quo;

  logic               ram_we;
  logic [IdxBits-1:0] ram_raddr;
  logic [PointBits-1:0] ram_rdata;
  logic [PointBits-1:0] pt_hold;
  dtok_t tok [NumCells+1];
  logic signed [CoordBits-1:0] rx, ry, rz;
  logic signed [CoordBits-1:0] cx [NumCells];
  logic signed [CoordBits-1:0] cy [NumCells];
  logic signed [CoordBits-1:0] cref [NumCells];
  logic signed [CoordBits-1:0] cq [NumCells];
  logic [PointBits-1:0] wpoint;

  logic accept;
  logic is_query;
  logic [SqBits-1:0]  trial;
  logic               root_bit;
  logic [DistBits-1:0] root_next;
  logic [SumBits:0]   dtrial;
  logic [SumBits:0]   sum_add;
  logic [SumBits-1:0] sum_sat;

  assign accept   = start && !busy;
  assign is_query = kind_t'(kind) == KIND_QUERY;
  assign wpoint   = {coord_x, coord_y, coord_z};
  assign ram_we   = accept && kind_t'(kind) == KIND_APPEND &&
                    ref_count < CntBits'(MaxRefPoints);
  assign ram_raddr = scan_cnt[IdxBits-1:0];
  assign scan_rd  = state == ST_SCAN && scan_cnt < ref_count;

  npp_ram #(.Width(PointBits), .Depth(MaxRefPoints)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ref_count[IdxBits-1:0]),
    .wdata (wpoint),
    .raddr (state == ST_SCAN ? ram_raddr : best_idx),
    .rdata (ram_rdata)
  );

  // skew reference coordinates so each cell sees its axis in step
  assign rx = ram_rdata[PointBits-1 -: CoordBits];
  always_ff @(posedge clk) begin
    pt_hold <= ram_rdata;
    ry      <= ram_rdata[2*CoordBits-1 -: CoordBits];
    rz      <= pt_hold[CoordBits-1:0];
  end
  assign cref[0] = rx;
  assign cref[1] = ry;
  assign cref[2] = rz;
  assign cq[0] = qx;
  assign cq[1] = qy;
  assign cq[2] = qz;
  assign cx = cref;
  assign cy = cq;

  assign tok[0].valid = rd_valid;
  assign tok[0].idx   = rd_idx;
  assign tok[0].acc   = '0;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    npp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .q    (cy[g]),
      .r    (cx[g]),
      .tin  (tok[g]),
      .tout (tok[g+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && is_query && ref_count != '0) state_next = ST_SCAN;
      ST_SCAN: if (!scan_rd && !rd_valid && !tok[1].valid && !tok[2].valid &&
                   !tok[3].valid) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_SQRT;
      ST_SQRT: if (step == 6'd0) state_next = qlast ? ST_DIV : ST_OUT;
      ST_DIV:  if (step == 6'd0) state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = state != ST_IDLE;
  end

  assign trial     = {sq_rem[SqBits-3:0], sq_val[SqBits-1 -: 2]};
  assign root_bit  = trial >= SqBits'({root, 2'b01});
  assign root_next = {root[DistBits-2:0], root_bit};
  assign sum_add   = {1'b0, dist_sum} + (SumBits+1)'(root_next);
  assign sum_sat   = sum_add[SumBits] ? '1 : sum_add[SumBits-1:0];
  assign dtrial    = {div_rem, div_quo[SumBits-1]} - (SumBits+1)'(query_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ref_count <= '0;
      dist_sum  <= '0;
      query_cnt <= '0;
      done      <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= (state == ST_OUT) || (accept && is_query && ref_count == '0);
      rd_valid <= scan_rd;
      if (ram_we) ref_count <= ref_count + 1'b1;
      if (accept && kind_t'(kind) == KIND_CLEAR) begin
        ref_count <= '0;
        dist_sum  <= '0;
        query_cnt <= '0;
      end
      // empty set answers at once
      if (accept && is_query && ref_count == '0) begin
        match_index      <= '0;
        match_x          <= '0;
        match_y          <= '0;
        match_z          <= '0;
        distance         <= '0;
        average_valid    <= 1'b0;
        average_distance <= '0;
        no_reference     <= 1'b1;
      end
      // add distance and count once root is known
      if (state == ST_SQRT && step == 6'd0) begin
        dist_sum <= sum_sat;
        if (query_cnt != '1) query_cnt <= query_cnt + 1'b1;
      end
      if (state == ST_OUT) begin
        match_index   <= 10'(best_idx);
        match_x       <= pt_hold[PointBits-1 -: CoordBits];
        match_y       <= pt_hold[2*CoordBits-1 -: CoordBits];
        match_z       <= pt_hold[CoordBits-1:0];
        distance      <= root;
        no_reference  <= 1'b0;
        average_valid <= qlast;
        average_distance <= !qlast ? '0 :
                            (div_quo > SumBits'({DistBits{1'b1}})) ? '1 :
                            div_quo[DistBits-1:0];
        if (qlast) begin
          dist_sum  <= '0;
          query_cnt <= '0;
        end
      end
    end
  end

  // datapath: scan, min tracking, root and quotient digit loops
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= coord_x;
      qy <= coord_y;
      qz <= coord_z;
      qlast <= last_query;
      scan_cnt <= '0;
      best_d <= '1;
      best_idx <= '0;
    end
    if (scan_rd) scan_cnt <= scan_cnt + 1'b1;
    rd_idx <= ram_raddr;
    if (tok[NumCells].valid && tok[NumCells].acc < best_d) begin
      best_d   <= tok[NumCells].acc;
      best_idx <= tok[NumCells].idx;
    end
    case (state)
      ST_FETCH: begin
        sq_val <= best_d;
        sq_rem <= '0;
        root   <= '0;
        step   <= 6'(SqrtSteps - 1);
      end
      ST_SQRT: begin
        sq_val <= sq_val << 2;
        if (root_bit) begin
          sq_rem <= trial - SqBits'({root, 2'b01});
        end else begin
          sq_rem <= trial;
        end
        root <= root_next;
        if (step != 6'd0) begin
          step <= step - 1'b1;
        end else begin
          step    <= 6'(SumBits - 1);
          div_rem <= '0;
          div_quo <= sum_sat;
        end
      end
      ST_DIV: begin
        if (!dtrial[SumBits]) begin
          div_rem <= dtrial[SumBits-1:0];
          div_quo <= {div_quo[SumBits-2:0], 1'b1};
        end else begin
          div_rem <= {div_rem[SumBits-2:0], div_quo[SumBits-1]};
          div_quo <= {div_quo[SumBits-2:0], 1'b0};
        end
        if (step != 6'd0) step <= step - 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  a_ref_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= CntBits'(MaxRefPoints)) else $error("reference count overflow");
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> busy) else $error("result state while not busy");
  a_div_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> qlast) else $error("division without last query");
`endif

endmodule

// ===== sim/tb_nearest_point_pairing.sv =====
`timescale 1ns / 1ps

module tb_nearest_point_pairing;
  import npp_pkg::*;

  typedef struct {
    kind_t             kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic              last;
  } point_cmd_t;

  typedef struct {
    logic [9:0]         index;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [16:0]        root_dist;
    logic               avg_valid;
    logic [16:0]        avg;
    logic               empty;
  } match_t;

  localparam longint unsigned SumMax = (64'd1 << 40) - 1;
  localparam longint unsigned QcMax  = (64'd1 << 21) - 1;
  localparam longint unsigned DistMax = (64'd1 << 17) - 1;

  logic clk, rst, start, busy, done;
  logic [1:0] kind;
  logic signed [15:0] coord_x, coord_y, coord_z;
  logic last_query;
  logic [9:0] match_index;
  logic signed [15:0] match_x, match_y, match_z;
  logic [16:0] distance, average_distance;
  logic average_valid, no_reference;

  nearest_point_pairing dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .last_query(last_query), .done(done), .match_index(match_index),
    .match_x(match_x), .match_y(match_y), .match_z(match_z),
    .distance(distance), .average_valid(average_valid),
    .average_distance(average_distance), .no_reference(no_reference)
  );

  point_cmd_t pending_cmds[$];
  match_t     expected_matches[$];
  int errors = 0;
  bit took = 0;
  int gap_left = 0;
  bit no_gaps = 0;

  // predictor copy of the point store and running sums
  logic signed [15:0] stored_pts[MaxRefPoints][3];
  int unsigned        stored_count = 0;
  longint unsigned    dist_total = 0;
  longint unsigned    query_total = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= v) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic longint unsigned sq_gap(logic signed [15:0] a, logic signed [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  task automatic apply_cmd(point_cmd_t c);
    match_t m;
    longint unsigned d, best_d, root;
    int unsigned best;
    m = '{default: '0};
    best = 0;
    best_d = '1;
    case (c.kind)
      KIND_APPEND: begin
        if (stored_count < MaxRefPoints) begin
          stored_pts[stored_count][0] = c.x;
          stored_pts[stored_count][1] = c.y;
          stored_pts[stored_count][2] = c.z;
          stored_count++;
        end
      end
      KIND_CLEAR: begin
        stored_count = 0;
        dist_total = 0;
        query_total = 0;
      end
      KIND_QUERY: begin
        if (stored_count == 0) begin
          m.empty = 1;
        end else begin
          for (int j = 0; j < stored_count; j++) begin
            d = sq_gap(c.x, stored_pts[j][0]) + sq_gap(c.y, stored_pts[j][1])
              + sq_gap(c.z, stored_pts[j][2]);
            if (d < best_d) begin
              best_d = d;
              best = j;
            end
          end
          root = floor_sqrt(best_d);
          dist_total += root;
          if (dist_total > SumMax) dist_total = SumMax;
          if (query_total < QcMax) query_total++;
          m.index = best[9:0];
          m.x = stored_pts[best][0];
          m.y = stored_pts[best][1];
          m.z = stored_pts[best][2];
          m.root_dist = root[16:0];
          if (c.last) begin
            d = dist_total / query_total;
            if (d > DistMax) d = DistMax;
            m.avg_valid = 1;
            m.avg = d[16:0];
            dist_total = 0;
            query_total = 0;
          end
        end
        expected_matches = {expected_matches, m};
      end
      default: ;
    endcase
  endtask

  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  // accept transfers and check results at the rising edge
  always @(posedge clk) begin
    match_t m;
    took <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      apply_cmd(pending_cmds[0]);
      pending_cmds.pop_front();
    end
    if (!rst && done) begin
      if (expected_matches.size() == 0) begin
        report("result with nothing expected");
      end else begin
        m = expected_matches.pop_front();
        if (no_reference !== m.empty) report("no_reference");
        if (match_index !== m.index) report($sformatf("match_index %0d exp %0d",
                                                      match_index, m.index));
        if (match_x !== m.x) report("match_x");
        if (match_y !== m.y) report("match_y");
        if (match_z !== m.z) report("match_z");
        if (distance !== m.root_dist) report($sformatf("distance %0d exp %0d", distance,
                                                       m.root_dist));
        if (average_valid !== m.avg_valid) report("average_valid");
        if (average_distance !== m.avg) report($sformatf("average_distance %0d exp %0d",
                                                         average_distance, m.avg));
      end
    end
  end

  // present commands at the falling edge, with random gaps
  always @(negedge clk) begin
    int g;
    g = gap_left;
    if (took) g = no_gaps ? 0 : $urandom_range(0, 15);
    if (rst) begin
      start <= 0;
      kind <= KIND_NONE;
      coord_x <= 0;
      coord_y <= 0;
      coord_z <= 0;
      last_query <= 0;
    end else if (start && !took) begin
      // hold the pending transfer
    end else if (g > 0) begin
      g--;
      start <= 0;
    end else if (pending_cmds.size() > 0) begin
      start <= 1;
      kind <= pending_cmds[0].kind;
      coord_x <= pending_cmds[0].x;
      coord_y <= pending_cmds[0].y;
      coord_z <= pending_cmds[0].z;
      last_query <= pending_cmds[0].last;
    end else begin
      start <= 0;
    end
    gap_left <= g;
  end

  task automatic push_cmd(kind_t k, int x, int y, int z, bit last);
    point_cmd_t c;
    c.kind = k;
    c.x = 16'(x);
    c.y = 16'(y);
    c.z = 16'(z);
    c.last = last;
    pending_cmds = {pending_cmds, c};
  endtask

  function automatic int pick_coord(int spread);
    if (spread == 0) return $signed(16'($urandom));
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_matches.size() == 0 && !start);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    int n_ref, n_q, spread, seen;
    rst = 1;
    repeat (6) @(negedge clk);
    rst <= 0;

    // directed: empty set, unused kind, extremes, ties, clear
    push_cmd(KIND_QUERY, 0, 0, 0, 1);
    push_cmd(KIND_NONE, 5, 5, 5, 1);
    push_cmd(KIND_QUERY, 1, 2, 3, 0);
    push_cmd(KIND_APPEND, -32768, -32768, -32768, 1);
    push_cmd(KIND_QUERY, 32767, 32767, 32767, 0);
    push_cmd(KIND_APPEND, 32767, 32767, 32767, 0);
    push_cmd(KIND_APPEND, 32767, 32767, 32767, 0);
    push_cmd(KIND_QUERY, 32767, 32767, 32767, 0);
    push_cmd(KIND_QUERY, 0, -1, 0, 0);
    push_cmd(KIND_APPEND, 100, 0, 0, 0);
    push_cmd(KIND_APPEND, -100, 0, 0, 0);
    push_cmd(KIND_QUERY, 0, 0, 0, 1);
    push_cmd(KIND_QUERY, -32768, 32767, -32768, 1);
    push_cmd(KIND_CLEAR, 7, 7, 7, 1);
    push_cmd(KIND_QUERY, 7, 7, 7, 1);
    push_cmd(KIND_APPEND, 12, -34, 56, 0);
    push_cmd(KIND_QUERY, 12, -34, 56, 1);
    push_cmd(KIND_QUERY, -12, 34, -56, 0);
    push_cmd(KIND_QUERY, 0, 0, 0, 1);
    drain();

    // load a large store, query at the far end
    no_gaps = 1;
    push_cmd(KIND_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 400; i++)
      push_cmd(KIND_APPEND, pick_coord(0), pick_coord(0), pick_coord(0), 0);
    drain();
    no_gaps = 0;
    push_cmd(KIND_QUERY, stored_pts[stored_count-1][0], stored_pts[stored_count-1][1],
             stored_pts[stored_count-1][2], 0);
    for (int i = 0; i < 4; i++)
      push_cmd(KIND_QUERY, pick_coord(0), pick_coord(0), pick_coord(0), i == 3);
    drain();

    // random batches: small sets, queries near the points, some noise
    seen = 0;
    while (seen < 130) begin
      spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
      n_ref = $urandom_range(0, 30);
      n_q = $urandom_range(1, 12);
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        push_cmd(KIND_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0), $urandom_range(0, 1));
        seen++;
      end
      for (int i = 0; i < n_ref; i++) begin
        if (i > 0 && $urandom_range(0, 5) == 0)
          push_cmd(KIND_APPEND, pending_cmds[$].x, pending_cmds[$].y, pending_cmds[$].z, 0);
        else
          push_cmd(KIND_APPEND, pick_coord(spread), pick_coord(spread), pick_coord(spread),
                   $urandom_range(0, 1));
      end
      for (int i = 0; i < n_q; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_cmd(KIND_NONE, pick_coord(0), pick_coord(0), pick_coord(0), $urandom_range(0, 1));
        push_cmd(KIND_QUERY, pick_coord(spread), pick_coord(spread), pick_coord(spread),
                 (i == n_q - 1) || ($urandom_range(0, 7) == 0));
      end
      seen += n_ref + n_q;
      if ($urandom_range(0, 3) == 0) drain();
      else wait (pending_cmds.size() == 0);
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb_nearest_point_pairing: done, clean");
    else $display("tb_nearest_point_pairing: done, errors");
    $finish;
  end

  initial begin
    #(8 * 4000000);
    $display("tb_nearest_point_pairing: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/npp_pkg.sv
rtl/npp_ram.sv
rtl/npp_cell.sv
rtl/nearest_point_pairing.sv
sim/tb_nearest_point_pairing.sv
